// File: hw/rtl/arfp_pkg.sv
`default_nettype none

package arfp_pkg;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int RANGE_W = 21;
	localparam int STAT_W  = 3;
	localparam int MAG_W   = 20;
	// Product width for magnitude * 10 + digit (values stay below 2^21)
	localparam int PROD_W  = MAG_W + 1;

	// Characters of interest
	localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CH_LF      = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR      = 8'd13;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;
	localparam logic [BYTE_W-1:0] CH_NINE    = 8'd57;
	localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_POINT   = 8'h2E;

	// Integer part cap and full scale of the range in hundredths
	localparam logic [MAG_W-1:0]  INT_CAP   = 20'd10000;
	localparam logic [PROD_W-1:0] RANGE_SAT = 21'd999999;

	// Frame parser phase
	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_BRK1  = 3'd1,
		PH_BRK2  = 3'd2,
		PH_INT   = 3'd3,
		PH_FRAC1 = 3'd4,
		PH_FRAC2 = 3'd5
	} phase_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_BRK1   = 3'd1,
		ST_NO_LF     = 3'd2,
		ST_NO_POINT  = 3'd3,
		ST_BAD_FRAC1 = 3'd4,
		ST_BAD_FRAC2 = 3'd5
	} status_t;

endpackage

`default_nettype wire

// File: hw/rtl/ascii_range_frame_parser_top.sv
`default_nettype none

// Byte-serial parser for ASCII range frames from a laser rangefinder.
// Input channel: one received character per beat on rx_byte (in_valid/in_ready).
// Output channel: one result beat per complete or broken frame, carrying
// range_hundredths (signed, centimetres, saturated at +/-999999) and status
// (0 ok, 1..5 error; range is zero on error) on out_valid/out_ready.
// Frame: '%', CR or LF, LF, integer digits (spaces skipped, '-' negates),
// '.', two fractional digits. Any other byte hunts for '%' again.
// An accepted byte is held in the input register and parsed as it moves on,
// which loads the output register; a result is thus offered from the output
// register once the byte that completes or breaks the frame is parsed.
// Throughput: one byte per cycle, set by the single input register feeding
// the parse logic (one multiply-by-ten add) into the output register.
// When the receiver stalls with a result pending, the parsed byte waits in
// the input register and in_ready drops until the output register drains.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// parser to hunting for '%' with the accumulator cleared.
module ascii_range_frame_parser_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic [arfp_pkg::BYTE_W-1:0]            rx_byte,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	output logic signed [arfp_pkg::RANGE_W-1:0]         range_hundredths,
	output logic [arfp_pkg::STAT_W-1:0]                 status,
	output logic                                        out_valid,
	input  wire logic                                   out_ready
);
	import arfp_pkg::*;

	logic [BYTE_W-1:0]        rx_byte_s1;
	logic                     valid_s1;
	phase_t                   phase_q, phase_d;
	logic [MAG_W-1:0]         mag_q, mag_d;
	logic                     neg_q, neg_d;
	logic                     out_valid_q;
	logic signed [RANGE_W-1:0] range_q;
	status_t                  status_q;

	logic                     advance, fire_s1, is_digit;
	logic [PROD_W-1:0]        prod;
	logic [PROD_W-1:0]        frac_sat;
	logic                     emit;
	logic signed [RANGE_W-1:0] res_range;
	status_t                  res_status;

	// Handshake: stage 1 moves on when the output register is free or draining
	assign advance  = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Digit decode and magnitude * 10 + digit
	assign is_digit = (rx_byte_s1 >= CH_ZERO) && (rx_byte_s1 <= CH_NINE);
	assign prod = ({1'b0, mag_q} << 3) + ({1'b0, mag_q} << 1)
		+ {{(PROD_W-4){1'b0}}, rx_byte_s1[3:0]};
	assign frac_sat = (prod > RANGE_SAT) ? RANGE_SAT : prod;

	// Next state
	always_comb begin
		phase_d = phase_q;
		mag_d   = mag_q;
		neg_d   = neg_q;
		case (phase_q)
			PH_BRK1: begin
				if (rx_byte_s1 inside {CH_LF, CH_CR}) begin
					phase_d = PH_BRK2;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_BRK2: begin
				phase_d = (rx_byte_s1 == CH_LF) ? PH_INT : PH_HUNT;
			end
			PH_INT: begin
				if (is_digit) begin
					mag_d = (prod > {1'b0, INT_CAP}) ? INT_CAP : prod[MAG_W-1:0];
				end else if (rx_byte_s1 == CH_SPACE) begin
					phase_d = PH_INT;
				end else if (rx_byte_s1 == CH_MINUS) begin
					neg_d = 1'b1;
				end else if (rx_byte_s1 == CH_POINT) begin
					phase_d = PH_FRAC1;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_FRAC1: begin
				if (is_digit) begin
					mag_d   = prod[MAG_W-1:0];
					phase_d = PH_FRAC2;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_FRAC2: begin
				phase_d = PH_HUNT;
			end
			default: begin
				if (rx_byte_s1 == CH_PERCENT) begin
					phase_d = PH_BRK1;
					mag_d   = '0;
					neg_d   = 1'b0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
		// any return to hunting clears the frame
		if (phase_d == PH_HUNT) begin
			mag_d = '0;
			neg_d = 1'b0;
		end
	end

	// Result decode
	always_comb begin
		emit       = 1'b0;
		res_range  = '0;
		res_status = ST_OK;
		case (phase_q)
			PH_BRK1: begin
				if (!(rx_byte_s1 inside {CH_LF, CH_CR})) begin
					emit       = 1'b1;
					res_status = ST_NO_BRK1;
				end
			end
			PH_BRK2: begin
				if (rx_byte_s1 != CH_LF) begin
					emit       = 1'b1;
					res_status = ST_NO_LF;
				end
			end
			PH_INT: begin
				if (!is_digit && !(rx_byte_s1 inside {CH_SPACE, CH_MINUS, CH_POINT})) begin
					emit       = 1'b1;
					res_status = ST_NO_POINT;
				end
			end
			PH_FRAC1: begin
				if (!is_digit) begin
					emit       = 1'b1;
					res_status = ST_BAD_FRAC1;
				end
			end
			PH_FRAC2: begin
				emit = 1'b1;
				if (is_digit) begin
					res_range = neg_q ? -$signed(frac_sat) : $signed(frac_sat);
				end else begin
					res_status = ST_BAD_FRAC2;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			mag_q   <= '0;
			neg_q   <= 1'b0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			mag_q   <= mag_d;
			neg_q   <= neg_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			range_q  <= res_range;
			status_q <= res_status;
		end
	end

	assign out_valid        = out_valid_q;
	assign range_hundredths = range_q;
	assign status           = status_q;

`ifndef SYNTHESIS
	// error results carry zero range
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_OK) |-> (range_q == '0))
		else $error("error result with non-zero range");

	// a result always sends the parser back to hunting
	a_emit_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && emit |=> (phase_q == PH_HUNT) && (mag_q == '0) && !neg_q)
		else $error("parser not cleared after result");

	// integer accumulator stays at or below its cap
	a_int_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_INT) |-> (mag_q <= INT_CAP))
		else $error("integer accumulator above cap");

	// an empty output register never blocks input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;

	import arfp_pkg::*;

	// Cycles without any beat on either channel before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// Bytes inside frames (not ignored while hunting) to send, directed part included
	localparam int FRAME_BYTES_TARGET = 1900;
	// Stretch of the random part run with both sides never idling
	localparam int CALM_FROM = 800;
	localparam int CALM_TO   = 1100;

	typedef struct packed {
		logic signed [RANGE_W-1:0] rng;
		status_t                   st;
	} range_result_t;

	// One directed byte; where fixed is set, the result is given here
	typedef struct packed {
		logic [BYTE_W-1:0]         b;
		bit                        fixed;
		bit                        has;
		logic signed [RANGE_W-1:0] rng;
		status_t                   st;
	} byte_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic [BYTE_W-1:0]          rx_byte = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [RANGE_W-1:0]  range_hundredths;
	logic [STAT_W-1:0]          status;
	logic                       out_valid;
	logic                       out_ready = 1'b0;

	// Predictor state
	phase_t                     frame_phase = PH_HUNT;
	logic [MAG_W-1:0]           frame_mag = '0;
	bit                         frame_neg = 1'b0;

	range_result_t              pending_ranges[$];
	logic [BYTE_W-1:0]          frame_bytes[$];
	int                         errors = 0;
	int                         in_frame_count = 0;
	int                         stall_cycles = 0;
	bit                         calm = 1'b0;

	// Directed bytes: stray bytes, each break error, huge negative value with a
	// minus after digits, and negative zero
	byte_row_t stim_table [0:25] = '{
		'{8'h00,      1'b1, 1'b0, '0,           ST_OK},
		'{CH_PERCENT, 1'b0, 1'b0, '0,           ST_OK},
		'{CH_PERCENT, 1'b1, 1'b1, '0,           ST_NO_BRK1},
		'{CH_LF,      1'b1, 1'b0, '0,           ST_OK},
		'{CH_PERCENT, 1'b0, 1'b0, '0,           ST_OK},
		'{CH_CR,      1'b0, 1'b0, '0,           ST_OK},
		'{8'hFF,      1'b1, 1'b1, '0,           ST_NO_LF},
		'{CH_PERCENT, 1'b0, 1'b0, '0,           ST_OK},
		'{CH_LF,      1'b0, 1'b0, '0,           ST_OK},
		'{CH_LF,      1'b0, 1'b0, '0,           ST_OK},
		'{CH_NINE,    1'b0, 1'b0, '0,           ST_OK},
		'{CH_NINE,    1'b0, 1'b0, '0,           ST_OK},
		'{CH_MINUS,   1'b0, 1'b0, '0,           ST_OK},
		'{CH_NINE,    1'b0, 1'b0, '0,           ST_OK},
		'{CH_NINE,    1'b0, 1'b0, '0,           ST_OK},
		'{CH_NINE,    1'b0, 1'b0, '0,           ST_OK},
		'{CH_POINT,   1'b0, 1'b0, '0,           ST_OK},
		'{CH_NINE,    1'b0, 1'b0, '0,           ST_OK},
		'{CH_NINE,    1'b1, 1'b1, -21'sd999999, ST_OK},
		'{CH_PERCENT, 1'b0, 1'b0, '0,           ST_OK},
		'{CH_LF,      1'b0, 1'b0, '0,           ST_OK},
		'{CH_LF,      1'b0, 1'b0, '0,           ST_OK},
		'{CH_MINUS,   1'b0, 1'b0, '0,           ST_OK},
		'{CH_POINT,   1'b0, 1'b0, '0,           ST_OK},
		'{CH_ZERO,    1'b0, 1'b0, '0,           ST_OK},
		'{CH_ZERO,    1'b1, 1'b1, '0,           ST_OK}
	};

	ascii_range_frame_parser_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.rx_byte          (rx_byte),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.range_hundredths (range_hundredths),
		.status           (status),
		.out_valid        (out_valid),
		.out_ready        (out_ready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Frame parser prediction for one accepted byte
	function automatic void parse_range_byte(input logic [BYTE_W-1:0] c, output bit got,
			output range_result_t res);
		int  m;
		bit  is_dig;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		m = int'(frame_mag) * 10 + int'(c - CH_ZERO);
		got = 1'b0;
		res = '{rng: '0, st: ST_OK};
		case (frame_phase)
			PH_BRK1: begin
				if (c == CH_LF || c == CH_CR)
					frame_phase = PH_BRK2;
				else begin
					got = 1'b1;
					res.st = ST_NO_BRK1;
				end
			end
			PH_BRK2: begin
				if (c == CH_LF)
					frame_phase = PH_INT;
				else begin
					got = 1'b1;
					res.st = ST_NO_LF;
				end
			end
			PH_INT: begin
				if (is_dig)
					frame_mag = (m > int'(INT_CAP)) ? INT_CAP : MAG_W'(m);
				else if (c == CH_MINUS)
					frame_neg = 1'b1;
				else if (c == CH_POINT)
					frame_phase = PH_FRAC1;
				else if (c != CH_SPACE) begin
					got = 1'b1;
					res.st = ST_NO_POINT;
				end
			end
			PH_FRAC1: begin
				if (is_dig) begin
					frame_mag = MAG_W'(m);
					frame_phase = PH_FRAC2;
				end else begin
					got = 1'b1;
					res.st = ST_BAD_FRAC1;
				end
			end
			PH_FRAC2: begin
				got = 1'b1;
				if (is_dig) begin
					if (m > int'(RANGE_SAT))
						m = int'(RANGE_SAT);
					res.rng = frame_neg ? RANGE_W'(-m) : RANGE_W'(m);
				end else
					res.st = ST_BAD_FRAC2;
			end
			default: begin
				if (c == CH_PERCENT) begin
					frame_mag = '0;
					frame_neg = 1'b0;
					frame_phase = PH_BRK1;
				end else
					frame_phase = PH_HUNT;
			end
		endcase
		// Every result, good or bad, sends the parser back to hunting
		if (got) begin
			frame_phase = PH_HUNT;
			frame_mag = '0;
			frame_neg = 1'b0;
		end
	endfunction

	// Random frame: mostly well formed, some cut short by a stray byte, some noise
	function automatic void build_frame();
		int kind;
		int ntok;
		int cut;
		int r;
		logic [BYTE_W-1:0] fb[$];
		kind = $urandom_range(99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 4))
				fb = {fb, BYTE_W'($urandom_range(255))};
		end else begin
			fb = {fb, CH_PERCENT};
			fb = {fb, ($urandom_range(1) ? CH_CR : CH_LF)};
			fb = {fb, CH_LF};
			ntok = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
			repeat (ntok) begin
				r = $urandom_range(19);
				if (r < 2)
					fb = {fb, CH_SPACE};
				else if (r < 3)
					fb = {fb, CH_MINUS};
				else
					fb = {fb, CH_ZERO + BYTE_W'($urandom_range(9))};
			end
			fb = {fb, CH_POINT};
			fb = {fb, CH_ZERO + BYTE_W'($urandom_range(9))};
			fb = {fb, CH_ZERO + BYTE_W'($urandom_range(9))};
			// Broken frame: cut it and put a random byte in place of the rest
			if (kind >= 75) begin
				cut = $urandom_range(1, fb.size() - 1);
				while (fb.size() > cut)
					void'(fb.pop_back());
				fb = {fb, BYTE_W'($urandom_range(255))};
			end
		end
		foreach (fb[i])
			frame_bytes = {frame_bytes, fb[i]};
	endfunction

	// Offer one byte beat, wait for it to be taken and record what it should give
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit fixed, input bit has,
			input range_result_t fixed_res);
		bit            got;
		range_result_t res;
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		if (frame_phase != PH_HUNT || b == CH_PERCENT)
			in_frame_count++;
		parse_range_byte(b, got, res);
		if (fixed) begin
			got = has;
			res = fixed_res;
		end
		if (got)
			pending_ranges = {pending_ranges, res};
	endtask

	// Stimulus and end of run
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_table[i])
			send_byte(stim_table[i].b, stim_table[i].fixed, stim_table[i].has,
				'{rng: stim_table[i].rng, st: stim_table[i].st});
		while (in_frame_count < FRAME_BYTES_TARGET) begin
			calm = (in_frame_count >= CALM_FROM) && (in_frame_count < CALM_TO);
			build_frame();
			while (frame_bytes.size() != 0)
				send_byte(frame_bytes.pop_front(), 1'b0, 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (pending_ranges.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver back-pressure
	always @(posedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);

	// Result beats against the oldest prediction
	always @(posedge clk) begin : check_ranges
		range_result_t exp;
		if (arst_n && out_valid && out_ready) begin
			if (pending_ranges.size() == 0) begin
				$display("%0t: unexpected result range %0d status %0d", $time,
					range_hundredths, status);
				errors++;
			end else begin
				exp = pending_ranges.pop_front();
				if (range_hundredths !== exp.rng) begin
					$display("%0t: range expected %0d got %0d", $time, exp.rng,
						range_hundredths);
					errors++;
				end
				if (status !== exp.st) begin
					$display("%0t: status expected %0d got %0d", $time, exp.st, status);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

endmodule

`default_nettype wire
